[design/xlb_pkg.sv]
// ----------------------------------------------------------------------------
// xlb_pkg
// shared types and constants for the xor linear basis block
// ----------------------------------------------------------------------------
package xlb_pkg;

  localparam int unsigned Width    = 32;
  localparam int unsigned IdxW     = $clog2(Width);
  localparam int unsigned CntW     = $clog2(Width + 1);
  localparam int unsigned RankW    = 33;
  localparam int unsigned FuncW    = 3;

  typedef logic [Width-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic [FuncW-1:0] {
    FN_CLEAR    = 3'd0,
    FN_INSERT   = 3'd1,
    FN_MAX      = 3'd2,
    FN_CONTAINS = 3'd3,
    FN_MIN      = 3'd4,
    FN_KTH      = 3'd5,
    FN_RSV6     = 3'd6,
    FN_RSV7     = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_REDUCE,
    ST_SELECT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic walk;      // one row per cycle, high to low (or low to high for min)
    logic reduce;    // one inner step of the reduction
    logic select;    // one row of the kth selection
    logic finish;    // last cycle before the result is shown
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic   walk_last;
    logic   red_last;
    logic   sel_last;
    logic   kth_skip;
    func_t  func;
  } stat_t;

endpackage

[design/xor_linear_basis_top.sv]
// ----------------------------------------------------------------------------
// xor_linear_basis_top
// gf(2) linear basis with insert, max, contains, min and kth queries
// ----------------------------------------------------------------------------
// usage:
//   input channel: func, value, rank_k with in_valid / in_stall.
//   output channel: result, flag, rank_now with out_valid / out_stall.
//   one item in, one item out, one item in flight at a time.
//   insert, max, contains and min walk the rows one per cycle through a
//   shared xor / compare unit.
//   kth copies the rows, reduces them pairwise and then selects over 32
//   rows; a kth item with rank zero goes straight to the result.
//   clear and unused codes go from the walk state straight to done.
//   the result waits in the done state while out_stall is high; no new
//   item is accepted until it is taken.
//   rst clears all rows, the zero flag and the row count.
// ----------------------------------------------------------------------------
module xor_linear_basis_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] value,
  input  logic [32:0] rank_k,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic        flag,
  output logic [5:0]  rank_now
);

  xlb_pkg::cmd_t  cmd;
  xlb_pkg::stat_t stat;

  xlb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  xlb_dp u_dp (
    .clk, .rst, .cmd, .stat, .func, .value, .rank_k, .result, .flag, .rank_now
  );

endmodule

[design/xlb_ctrl.sv]
// ----------------------------------------------------------------------------
// xlb_ctrl
// sequencer for the xor linear basis operations
// ----------------------------------------------------------------------------
module xlb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  xlb_pkg::stat_t stat,
  output xlb_pkg::cmd_t  cmd
);

  xlb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xlb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      xlb_pkg::ST_IDLE: begin
        if (in_valid) state_next = xlb_pkg::ST_WALK;
      end
      xlb_pkg::ST_WALK: begin
        if (stat.func == xlb_pkg::FN_KTH) begin
          state_next = stat.kth_skip ? xlb_pkg::ST_DONE : xlb_pkg::ST_REDUCE;
        end else if (stat.walk_last || stat.func inside {xlb_pkg::FN_CLEAR,
                     xlb_pkg::FN_RSV6, xlb_pkg::FN_RSV7}) begin
          state_next = xlb_pkg::ST_DONE;
        end
      end
      xlb_pkg::ST_REDUCE: begin
        if (stat.red_last) state_next = xlb_pkg::ST_SELECT;
      end
      xlb_pkg::ST_SELECT: begin
        if (stat.sel_last) state_next = xlb_pkg::ST_DONE;
      end
      xlb_pkg::ST_DONE: begin
        if (!out_stall) state_next = xlb_pkg::ST_IDLE;
      end
      default: state_next = xlb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = (state != xlb_pkg::ST_IDLE);
    out_valid  = (state == xlb_pkg::ST_DONE);
    case (state)
      xlb_pkg::ST_IDLE:   cmd.load = in_valid;
      xlb_pkg::ST_WALK: begin
        cmd.walk      = 1'b1;
        cmd.finish    = (state_next == xlb_pkg::ST_DONE);
      end
      xlb_pkg::ST_REDUCE: cmd.reduce = 1'b1;
      xlb_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
        cmd.finish = stat.sel_last;
      end
      default: ;
    endcase
  end

  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == xlb_pkg::ST_DONE) else $error("out_valid outside done");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == xlb_pkg::ST_IDLE) else $error("load while busy");

endmodule

[design/xlb_dp.sv]
// ----------------------------------------------------------------------------
// xlb_dp
// basis rows and the shared walk / reduce / select datapath
// ----------------------------------------------------------------------------
module xlb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  xlb_pkg::cmd_t                 cmd,
  output xlb_pkg::stat_t                stat,
  input  logic [xlb_pkg::FuncW-1:0]     func,
  input  logic [31:0]                   value,
  input  logic [xlb_pkg::RankW-1:0]     rank_k,
  output logic [31:0]                   result,
  output logic                          flag,
  output logic [5:0]                    rank_now
);

  xlb_pkg::word_t             rows [xlb_pkg::Width];
  xlb_pkg::word_t             red  [xlb_pkg::Width];
  logic                       zero_reachable;
  logic [xlb_pkg::CntW-1:0]   row_count;
  xlb_pkg::func_t             op;
  xlb_pkg::word_t             acc;
  logic                       done_bit;    // early finish or failure
  logic                       ok;
  logic [xlb_pkg::RankW-1:0]  m;
  logic [xlb_pkg::CntW-1:0]   i_cnt;       // walk / outer row index
  logic [xlb_pkg::CntW-1:0]   j_cnt;       // inner reduce index plus one
  logic [xlb_pkg::CntW-1:0]   j_dec;

  xlb_pkg::idx_t  wi, ri, rj;
  xlb_pkg::word_t row_w, t, cur_i, red_j, sel_acc;
  logic           last_i;
  logic           sel_take;
  logic [xlb_pkg::RankW-1:0]  m_left;

  // min walks upward, the others downward
  assign wi     = (op == xlb_pkg::FN_MIN) ? i_cnt[xlb_pkg::IdxW-1:0]
                : xlb_pkg::IdxW'(xlb_pkg::Width - 1) - i_cnt[xlb_pkg::IdxW-1:0];
  assign row_w  = rows[wi];
  assign t      = acc ^ row_w;
  assign last_i = (i_cnt == xlb_pkg::CntW'(xlb_pkg::Width - 1));
  assign ri     = i_cnt[xlb_pkg::IdxW-1:0];
  assign j_dec  = j_cnt - 1'b1;
  assign rj     = j_dec[xlb_pkg::IdxW-1:0];

  // reduction: during REDUCE, i_cnt is row i, row j = j_cnt - 1 counts down
  assign cur_i  = red[ri];
  assign red_j  = red[rj];

  // selection: nonzero reduced rows take successive bits of m, low first
  assign sel_take = (cur_i != '0);
  assign sel_acc  = (sel_take && m[0]) ? (acc ^ cur_i) : acc;
  assign m_left   = sel_take ? (m >> 1) : m;

  assign stat.func      = op;
  assign stat.walk_last = last_i || done_bit;
  assign stat.red_last  = last_i && (j_cnt == '0);
  assign stat.sel_last  = last_i;
  assign stat.kth_skip  = (m == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < xlb_pkg::Width; k++) rows[k] <= '0;
      zero_reachable <= 1'b0;
      row_count      <= '0;
      op             <= xlb_pkg::FN_CLEAR;
    end else if (cmd.load) begin
      op       <= xlb_pkg::func_t'(func);
      acc      <= value;
      m        <= rank_k;
      i_cnt    <= '0;
      done_bit <= 1'b0;
      ok       <= 1'b0;
      if (xlb_pkg::func_t'(func) == xlb_pkg::FN_CLEAR) begin
        for (int k = 0; k < xlb_pkg::Width; k++) rows[k] <= '0;
        zero_reachable <= 1'b0;
        row_count      <= '0;
      end
    end else if (cmd.walk && !done_bit) begin
      if (op == xlb_pkg::FN_KTH) begin
        // reduce a copy so the stored rows stay untouched
        for (int k = 0; k < xlb_pkg::Width; k++) red[k] <= rows[k];
        i_cnt <= '0;
        j_cnt <= '0;
        acc   <= '0;
        // rank zero is never valid and ends here with ok low
        if (m != '0 && zero_reachable) m <= m - 1'b1;
      end else begin
        i_cnt <= i_cnt + 1'b1;
        case (op)
          xlb_pkg::FN_INSERT: begin
            if (acc[wi]) begin
              if (row_w == '0) begin
                rows[wi]  <= acc;
                row_count <= row_count + 1'b1;
                ok        <= 1'b1;
                done_bit  <= 1'b1;
              end else begin
                acc <= t;
              end
            end
            if (last_i && !(acc[wi] && row_w == '0)) zero_reachable <= 1'b1;
          end
          xlb_pkg::FN_MAX: if (t > acc) acc <= t;
          xlb_pkg::FN_CONTAINS: begin
            if (acc[wi]) begin
              if (row_w == '0) begin
                done_bit <= 1'b1;
                ok       <= 1'b0;
              end else begin
                acc <= t;
              end
            end
            if (last_i && !(acc[wi] && row_w == '0)) ok <= 1'b1;
          end
          xlb_pkg::FN_MIN: begin
            if (zero_reachable) begin
              acc <= '0; ok <= 1'b1; done_bit <= 1'b1;
            end else if (row_w != '0) begin
              acc <= row_w; ok <= 1'b1; done_bit <= 1'b1;
            end else if (last_i) begin
              acc <= '0;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.reduce) begin
      if (j_cnt != '0) begin
        if (cur_i[rj]) red[ri] <= cur_i ^ red_j;
        j_cnt <= j_cnt - 1'b1;
      end else if (!last_i) begin
        i_cnt <= i_cnt + 1'b1;
        j_cnt <= i_cnt + 1'b1;
      end else begin
        i_cnt <= '0;
      end
    end else if (cmd.select) begin
      i_cnt <= i_cnt + 1'b1;
      acc   <= sel_acc;
      m     <= m_left;
      // every bit of the rank must be used up by the last row
      if (cmd.finish) ok <= (m_left == '0);
    end
  end

  // final output selection
  always_comb begin
    result   = '0;
    flag     = 1'b0;
    rank_now = 6'(row_count);
    case (op)
      xlb_pkg::FN_MAX:      result = acc;
      xlb_pkg::FN_CONTAINS: flag   = ok;
      xlb_pkg::FN_INSERT:   flag   = ok;
      xlb_pkg::FN_MIN: begin
        result = ok ? acc : '0;
        flag   = ok;
      end
      xlb_pkg::FN_KTH: begin
        result = ok ? acc : '0;
        flag   = ok;
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= xlb_pkg::CntW'(xlb_pkg::Width)) else $error("row count overflow");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && func == xlb_pkg::FN_CLEAR) |=> (row_count == '0))
    else $error("clear missed");
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (row_count != $past(row_count)) |-> (op == xlb_pkg::FN_INSERT || op == xlb_pkg::FN_CLEAR))
    else $error("row count changed by a query");

endmodule

[sim/xor_linear_basis_top_tb.sv]
// ----------------------------------------------------------------------------
// xor_linear_basis_top_tb
// drives clear, insert, max, contains, min, kth and unused-code items into the basis block,
// with random gaps and stalls on both channels, and checks every returned
// item against a local model of the gf(2) basis
// ----------------------------------------------------------------------------
module xor_linear_basis_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 790;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [31:0] result;
    logic        flag;
    logic [5:0]  rank_now;
  } answer_t;

  typedef struct {
    xlb_pkg::func_t fn;
    logic [31:0]    value;
    logic [32:0]    rank_k;
    logic           typed;     // expected answer written in the row
    answer_t        ans;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  logic [31:0] value;
  logic [32:0] rank_k;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result;
  logic        flag;
  logic [5:0]  rank_now;

  xor_linear_basis_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .value(value), .rank_k(rank_k),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .flag(flag), .rank_now(rank_now)
  );

  // local copy of the basis
  logic [31:0] rows [32];
  logic        zero_hit;
  logic [5:0]  row_total;

  answer_t pending_answers[$];
  int unsigned fail_count;
  longint unsigned cycle_count;
  bit          stim_done;

  function automatic answer_t basis_apply(xlb_pkg::func_t fn, logic [31:0] v,
                                          logic [32:0] k);
    answer_t a;
    logic [31:0] w;
    logic [31:0] t;
    logic [31:0] tmp [32];
    logic [31:0] red [32];
    logic [32:0] m;
    int n;
    bit done;
    a.result = '0;
    a.flag = 1'b0;
    w = v;
    case (fn)
      xlb_pkg::FN_CLEAR: begin
        foreach (rows[i]) rows[i] = '0;
        zero_hit = 1'b0;
        row_total = '0;
      end
      xlb_pkg::FN_INSERT: begin
        done = 0;
        for (int i = 31; i >= 0 && !done; i--) begin
          if (w[i]) begin
            if (rows[i] == '0) begin
              rows[i] = w;
              row_total++;
              a.flag = 1'b1;
              done = 1;
            end else begin
              w ^= rows[i];
            end
          end
        end
        if (!done) zero_hit = 1'b1;
      end
      xlb_pkg::FN_MAX: begin
        for (int i = 31; i >= 0; i--) begin
          t = w ^ rows[i];
          if (t > w) w = t;
        end
        a.result = w;
      end
      xlb_pkg::FN_CONTAINS: begin
        a.flag = 1'b1;
        for (int i = 31; i >= 0 && a.flag; i--) begin
          if (w[i]) begin
            if (rows[i] == '0) a.flag = 1'b0;
            else w ^= rows[i];
          end
        end
      end
      xlb_pkg::FN_MIN: begin
        if (zero_hit) begin
          a.flag = 1'b1;
        end else begin
          for (int i = 0; i < 32 && !a.flag; i++) begin
            if (rows[i] != '0) begin
              a.result = rows[i];
              a.flag = 1'b1;
            end
          end
        end
      end
      xlb_pkg::FN_KTH: begin
        if (k != '0) begin
          n = 0;
          for (int i = 0; i < 32; i++) tmp[i] = rows[i];
          for (int i = 0; i < 32; i++) begin
            if (tmp[i] != '0) begin
              for (int j = i - 1; j >= 0; j--)
                if (tmp[i][j]) tmp[i] ^= tmp[j];
              red[n] = tmp[i];
              n++;
            end
          end
          m = zero_hit ? k - 33'd1 : k;
          if ((m >> n) == '0) begin
            a.flag = 1'b1;
            for (int i = 0; i < n; i++)
              if (m[i]) a.result ^= red[i];
          end
        end
      end
      default: ;
    endcase
    a.rank_now = row_total;
    return a;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 4) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(xlb_pkg::func_t fn, logic [31:0] v, logic [32:0] k,
                           logic typed, answer_t want);
    answer_t a;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= fn;
    value <= v;
    rank_k <= k;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    a = basis_apply(fn, v, k);
    if (typed && a != want) begin
      $error("table row disagrees with model: func %0d value %h", fn, v);
      fail_count++;
    end
    pending_answers = {pending_answers, a};
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h1 << $urandom_range(0, 31);
      2: return $urandom() & ($urandom() | 32'h0000_00FF);
      3: return $urandom() & 32'h0000_000F;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [32:0] rand_rank();
    case ($urandom_range(0, 4))
      0: return {1'b1, 32'h0};
      1: return {1'($urandom_range(0, 1)), $urandom()};
      2: return '0;
      default: return 33'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic answer_t ans(logic [31:0] r, logic f, logic [5:0] c);
    answer_t a;
    a.result = r;
    a.flag = f;
    a.rank_now = c;
    return a;
  endfunction

  stim_row_t table_rows[$];
  answer_t   no_ans;

  initial begin
    xlb_pkg::func_t fn;
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    value = '0;
    rank_k = '0;
    stim_done = 0;
    foreach (rows[i]) rows[i] = '0;
    zero_hit = 1'b0;
    row_total = '0;
    no_ans = ans('0, 1'b0, '0);
    table_rows = '{
      '{xlb_pkg::FN_MIN,      32'h0,         33'h0,    1'b1, ans(32'h0, 1'b0, 6'd0)},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h1,    1'b1, ans(32'h0, 1'b0, 6'd0)},
      '{xlb_pkg::FN_CONTAINS, 32'h0,         33'h0,    1'b1, ans(32'h0, 1'b1, 6'd0)},
      '{xlb_pkg::FN_MAX,      32'hFFFF_FFFF, 33'h0,    1'b1,
        ans(32'hFFFF_FFFF, 1'b0, 6'd0)},
      '{xlb_pkg::FN_INSERT,   32'h8000_0000, 33'h0,    1'b1, ans(32'h0, 1'b1, 6'd1)},
      '{xlb_pkg::FN_INSERT,   32'h0000_0001, 33'h0,    1'b1, ans(32'h0, 1'b1, 6'd2)},
      '{xlb_pkg::FN_MIN,      32'h0,         33'h0,    1'b1, ans(32'h1, 1'b1, 6'd2)},
      '{xlb_pkg::FN_INSERT,   32'hFFFF_FFFF, 33'h0,    1'b0, no_ans},
      '{xlb_pkg::FN_CONTAINS, 32'h7FFF_FFFF, 33'h0,    1'b0, no_ans},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h0,    1'b0, no_ans},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h8,    1'b0, no_ans},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h9,    1'b0, no_ans},
      '{xlb_pkg::FN_INSERT,   32'h0,         33'h0,    1'b0, no_ans},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h1,    1'b0, no_ans},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h1_0000_0000, 1'b0, no_ans},
      '{xlb_pkg::FN_MAX,      32'h0,         33'h0,    1'b0, no_ans},
      '{xlb_pkg::FN_RSV6,     32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 1'b0, no_ans},
      '{xlb_pkg::FN_RSV7,     32'h1234_5678, 33'h3,    1'b0, no_ans},
      '{xlb_pkg::FN_CLEAR,    32'hFFFF_FFFF, 33'h0,    1'b1, ans(32'h0, 1'b0, 6'd0)},
      '{xlb_pkg::FN_CONTAINS, 32'h0000_0002, 33'h0,    1'b1, ans(32'h0, 1'b0, 6'd0)},
      '{xlb_pkg::FN_INSERT,   32'h0,         33'h0,    1'b1, ans(32'h0, 1'b0, 6'd0)},
      '{xlb_pkg::FN_MIN,      32'h0,         33'h0,    1'b1, ans(32'h0, 1'b1, 6'd0)},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h1,    1'b1, ans(32'h0, 1'b1, 6'd0)},
      '{xlb_pkg::FN_KTH,      32'h0,         33'h2,    1'b1, ans(32'h0, 1'b0, 6'd0)}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (table_rows[i])
      send_item(table_rows[i].fn, table_rows[i].value, table_rows[i].rank_k,
                table_rows[i].typed, table_rows[i].ans);
    // fill the basis to full rank once: one bit per row
    for (int b = 0; b < 32; b++)
      send_item(xlb_pkg::FN_INSERT, 32'h1 << b, '0, 1'b0, no_ans);
    send_item(xlb_pkg::FN_KTH, '0, {1'b1, 32'h0}, 1'b0, no_ans);
    send_item(xlb_pkg::FN_KTH, '0, 33'h0_FFFF_FFFF, 1'b0, no_ans);
    send_item(xlb_pkg::FN_MIN, '0, '0, 1'b0, no_ans);
    // wait until everything drained
    in_valid <= 1'b0;
    wait (pending_answers.size() == 0);
    @(negedge clk);
    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 19))
        0:           fn = xlb_pkg::FN_CLEAR;
        1:           fn = xlb_pkg::func_t'(3'($urandom_range(6, 7)));
        2, 3, 4:     fn = xlb_pkg::FN_MAX;
        5, 6, 7:     fn = xlb_pkg::FN_CONTAINS;
        8, 9:        fn = xlb_pkg::FN_MIN;
        10, 11:      fn = xlb_pkg::FN_KTH;
        default:     fn = xlb_pkg::FN_INSERT;
      endcase
      send_item(fn, rand_word(), rand_rank(), 1'b0, no_ans);
      if (i == NumRandom / 2) begin
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver stall, with one long hold-off early in the run
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    repeat (200) @(negedge clk);
    out_stall <= 1'b1;
    repeat (3000) @(negedge clk);
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected item: result %h flag %b rank_now %0d", result, flag, rank_now);
        fail_count++;
      end else begin
        w = pending_answers.pop_front();
        if (result !== w.result) begin
          $error("result: expected %h, got %h", w.result, result);
          fail_count++;
        end
        if (flag !== w.flag) begin
          $error("flag: expected %b, got %b", w.flag, flag);
          fail_count++;
        end
        if (rank_now !== w.rank_now) begin
          $error("rank_now: expected %0d, got %0d", w.rank_now, rank_now);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done && pending_answers.size() == 0);
        repeat (700) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0) begin
          $display("xor_linear_basis_top_tb: PASS");
        end else begin
          $display("xor_linear_basis_top_tb: FAIL");
        end
      end
      begin
        while (cycle_count < CycleLimit) begin
          @(posedge clk);
          cycle_count++;
        end
        $display("xor_linear_basis_top_tb: FAIL");
      end
    join_any
    $finish;
  end

endmodule

[sim.f]
design/xlb_pkg.sv
design/xlb_ctrl.sv
design/xlb_dp.sv
design/xor_linear_basis_top.sv
sim/xor_linear_basis_top_tb.sv
